### hdl/qat_pkg.sv
// ----------------------------------------------------------------------------
// qat_pkg
// Shared types and character constants for the quoted argument tokenizer.
// ----------------------------------------------------------------------------
package qat_pkg;

  localparam int unsigned MaxTokensDefault = 255;
  localparam int unsigned CountMax         = 255;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChReturn    = 8'h0D;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChSingleQ   = 8'h27;
  localparam logic [7:0] ChDoubleQ   = 8'h22;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_OK   = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_SINGLE = 2'd1,
    QUOTE_DOUBLE = 2'd2
  } quote_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    logic [7:0]  token_number;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic        escape_active;
    quote_e      open_quote;
    logic        prev_backslash;
    logic        token_open;
    logic [7:0]  token_count;
  } tok_state_t;

  typedef struct packed {
    logic [1:0]  num;
    result_t     first;
    result_t     second;
  } step_out_t;

endpackage

### hdl/qat_step.sv
// ----------------------------------------------------------------------------
// qat_step
// Per-byte state update: escape tracking, quote spans, token boundaries and
// the up to two results caused by one input item.
// ----------------------------------------------------------------------------
module qat_step #(
  parameter int unsigned MAX_TOKENS = qat_pkg::MaxTokensDefault
) (
  input  qat_pkg::tok_state_t state_i,
  input  logic [7:0]          char_byte_i,
  input  logic                end_of_line_i,
  output qat_pkg::tok_state_t state_o,
  output qat_pkg::step_out_t  step_o
);
  import qat_pkg::*;

  localparam int unsigned CountCap = (MAX_TOKENS < CountMax) ? MAX_TOKENS : CountMax;

  logic       esc;
  logic [7:0] ch;
  logic       blank;
  logic       is_quote;
  quote_e     quote_kind;
  logic [7:0] count_inc;
  logic [7:0] quote_byte;

  always_comb begin
    esc = state_i.prev_backslash ? ~state_i.escape_active : 1'b0;

    ch = char_byte_i;
    if (esc) begin
      case (char_byte_i)
        ChLowerN: ch = ChNewline;
        ChLowerR: ch = ChReturn;
        ChLowerT: ch = ChTab;
        default:  ch = char_byte_i;
      endcase
    end

    blank      = (ch == ChSpace) || (ch == ChTab);
    is_quote   = (ch == ChSingleQ) || (ch == ChDoubleQ);
    quote_kind = (ch == ChSingleQ) ? QUOTE_SINGLE : QUOTE_DOUBLE;

    // Token count saturates at the configured limit, or at CountMax if that is lower.
    count_inc = (state_i.token_count < CountCap[7:0]) ?
                state_i.token_count + 8'd1 : state_i.token_count;

    case (state_i.open_quote)
      QUOTE_SINGLE: quote_byte = ChSingleQ;
      QUOTE_DOUBLE: quote_byte = ChDoubleQ;
      default:      quote_byte = 8'h00;
    endcase

    state_o = state_i;
    step_o  = '0;
    step_o.first.token_number  = state_i.token_count;
    step_o.second.token_number = state_i.token_count;

    if (end_of_line_i) begin
      state_o = '0;
      if (state_i.open_quote != QUOTE_NONE) begin
        step_o.num               = 2'd1;
        step_o.first.kind        = KIND_ERR;
        step_o.first.value       = quote_byte;
        step_o.first.last_result = 1'b1;
      end else if (state_i.token_open) begin
        step_o.num                  = 2'd2;
        step_o.first.kind           = KIND_END;
        step_o.first.token_number   = count_inc;
        step_o.second.kind          = KIND_OK;
        step_o.second.token_number  = count_inc;
        step_o.second.last_result   = 1'b1;
      end else begin
        step_o.num               = 2'd1;
        step_o.first.kind        = KIND_OK;
        step_o.first.last_result = 1'b1;
      end
    end else begin
      state_o.escape_active  = esc;
      state_o.prev_backslash = (ch == ChBackslash);
      step_o.first.last_result = 1'b1;
      if ((state_i.open_quote == QUOTE_NONE) && blank) begin
        if (state_i.token_open) begin
          state_o.token_count       = count_inc;
          state_o.token_open        = 1'b0;
          step_o.num                = 2'd1;
          step_o.first.kind         = KIND_END;
          step_o.first.token_number = count_inc;
        end
      end else if (!esc && is_quote) begin
        if (state_i.open_quote == QUOTE_NONE) begin
          state_o.open_quote = quote_kind;
        end else if (state_i.open_quote == quote_kind) begin
          state_o.open_quote = QUOTE_NONE;
        end else begin
          // A quote of the other kind inside a span is an ordinary byte.
          state_o.token_open = 1'b1;
          step_o.num         = 2'd1;
          step_o.first.kind  = KIND_BYTE;
          step_o.first.value = ch;
        end
      end else if ((ch != ChBackslash) || esc) begin
        state_o.token_open = 1'b1;
        step_o.num         = 2'd1;
        step_o.first.kind  = KIND_BYTE;
        step_o.first.value = ch;
      end
    end
  end

endmodule

### hdl/qat_out_fifo.sv
// ----------------------------------------------------------------------------
// qat_out_fifo
// Three-entry result queue that takes up to two results per cycle and
// hands one result per transfer to the output channel.
// ----------------------------------------------------------------------------
module qat_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_num_i,
  input  qat_pkg::result_t push0_i,
  input  qat_pkg::result_t push1_i,
  input  logic             pop_i,
  output qat_pkg::result_t head_o,
  output logic             not_empty_o,
  output logic             room2_o
);
  import qat_pkg::*;

  localparam int unsigned Depth = 3;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    ptr_inc = (p == 2'(Depth - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  result_t    mem_q [Depth];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic [1:0] wr_ptr_next;
  logic [1:0] count_after_pop;

  assign wr_ptr_next     = ptr_inc(wr_ptr_q);
  assign count_after_pop = count_q - {1'b0, pop_i};
  assign room2_o         = (count_after_pop <= 2'd1);
  assign not_empty_o     = (count_q != 2'd0);
  assign head_o          = mem_q[rd_ptr_q];

  always_comb begin
    count_d  = count_after_pop + push_num_i;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    case (push_num_i)
      2'd1:    wr_ptr_d = wr_ptr_next;
      2'd2:    wr_ptr_d = ptr_inc(wr_ptr_next);
      default: wr_ptr_d = wr_ptr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr_ptr_next] <= push1_i;
    end
  end

endmodule

### hdl/quoted_argument_tokenizer.sv
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer
// Splits a command line into shell-style arguments, one byte per transfer.
// ----------------------------------------------------------------------------
// Usage: bytes of a command line arrive on the input channel (char_byte_i),
// and a transfer with end_of_line_i set closes the line. Each input transfer
// causes zero, one or two results on the output channel: token bytes, token
// ends, a line-ok marker or an unterminated-quote error. last_result_o marks
// the final result caused by an input transfer; a transfer that causes no
// result produces nothing on the output.
// The byte is registered on input and, when the queue has room for two more
// results, processed by the step logic into a three-entry result queue that
// drives the output channel. Throughput is one input transfer per cycle while
// the queue has that room; an end of line that closes a token yields two
// results, which leave the output one per transfer.
// When the receiver stalls, results wait in the queue and input is still
// taken while the queue has room for two more results.
// Reset clears the tokenizer state, the input valid flag and the queue pointers and count.
// ----------------------------------------------------------------------------
module quoted_argument_tokenizer #(
  parameter int unsigned MAX_TOKENS = qat_pkg::MaxTokensDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       end_of_line_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] value_o,
  output logic [7:0] token_number_o,
  output logic       last_result_o
);
  import qat_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_eol_q;
  logic       s1_fire;

  tok_state_t state_q;
  tok_state_t state_next;
  step_out_t  step;

  result_t    head;
  logic       room2;
  logic       pop;
  logic [1:0] push_num;

  qat_step #(
    .MAX_TOKENS(MAX_TOKENS)
  ) u_step (
    .state_i      (state_q),
    .char_byte_i  (s1_char_q),
    .end_of_line_i(s1_eol_q),
    .state_o      (state_next),
    .step_o       (step)
  );

  assign pop        = out_valid_o && out_ready_i;
  assign s1_fire    = s1_valid_q && room2;
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign push_num   = s1_fire ? step.num : 2'd0;

  qat_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (push_num),
    .push0_i    (step.first),
    .push1_i    (step.second),
    .pop_i      (pop),
    .head_o     (head),
    .not_empty_o(out_valid_o),
    .room2_o    (room2)
  );

  assign kind_o         = head.kind;
  assign value_o        = head.value;
  assign token_number_o = head.token_number;
  assign last_result_o  = head.last_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_fire) begin
        state_q <= state_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_char_q <= char_byte_i;
      s1_eol_q  <= end_of_line_i;
    end
  end

endmodule
